[rtl/cdr_pkg.sv]
// Shared types, register codes and the CRC-8 step for the datagram receiver.
package cdr_pkg;

	localparam int unsigned NUM_REGS = 3;
	localparam int unsigned ADDR_WIDTH = 4;
	localparam int unsigned DATA_WIDTH = 32;

	localparam logic [1:0] REG_START_BYTE = 2'd0;
	localparam logic [1:0] REG_CRC_POLYNOMIAL = 2'd1;
	localparam logic [1:0] REG_GAP_LIMIT_TICKS = 2'd2;

	localparam logic [7:0] RESET_START_BYTE = 8'd17;
	localparam logic [7:0] RESET_CRC_POLYNOMIAL = 8'd140;
	localparam logic [7:0] RESET_GAP_LIMIT_TICKS = 8'd10;

	localparam logic [7:0] MIN_FRAME_LENGTH = 8'd4;
	localparam logic [2:0] MAX_PAYLOAD = 3'd4;
	localparam int unsigned NUM_PAYLOAD = 4;
	localparam int unsigned STORE_SLOTS = 6;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_START,
		KIND_TICK
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LENGTH,
		PH_BODY
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_CRC = 3'd1,
		ST_LEN = 3'd2,
		ST_TIMEOUT = 3'd3,
		ST_STRAY = 3'd4
	} status_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		status_t status;
		logic [7:0] frame_length;
		logic [7:0] dest_address;
		logic [7:0] op_code;
		logic [2:0] payload_count;
		logic [NUM_PAYLOAD-1:0][7:0] payload;
		logic [7:0] stray_value;
	} result_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[rtl/cdr_front.sv]
// Input side: accept words, tag them as byte, start byte or tick, and push them on.
module cdr_front (
	input  logic                push,
	output logic                full,
	input  logic                cmd,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          start_byte,
	input  logic                q_full,
	output logic                q_push,
	output cdr_pkg::item_t      q_item
);

	assign full = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		q_item.data = rx_byte;
		if (cmd) begin
			q_item.kind = cdr_pkg::KIND_TICK;
		end else if (rx_byte == start_byte) begin
			q_item.kind = cdr_pkg::KIND_START;
		end else begin
			q_item.kind = cdr_pkg::KIND_BYTE;
		end
	end

endmodule

[rtl/cdr_queue.sv]
// Two-entry queue between the front and the parser.
module cdr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  cdr_pkg::item_t      wr_item,
	output logic                q_full,
	input  logic                rd_en,
	output logic                rd_valid,
	output cdr_pkg::item_t      rd_item
);

	cdr_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign q_full = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

[rtl/cdr_back.sv]
// Frame parser: length check, CRC-8, gap timer, frame store and the result register.
module cdr_back #(
	parameter int unsigned MAX_FRAME_LENGTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  cdr_pkg::item_t      q_item,
	output logic                q_pop,
	input  logic [7:0]          crc_polynomial,
	input  logic [7:0]          gap_limit_ticks,
	input  logic                pop,
	output logic                empty,
	output cdr_pkg::result_t    result
);

	localparam int unsigned STORE_DEPTH = MAX_FRAME_LENGTH - 2;
	localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_LENGTH);

	cdr_pkg::phase_t  phase_q, phase_d;
	logic [7:0]       expected_length_q, expected_length_d;
	logic [3:0]       bytes_seen_q, bytes_seen_d;
	logic [7:0]       running_crc_q, running_crc_d;
	logic [7:0]       gap_q, gap_d;
	logic [7:0]       store_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] store_we;
	logic [cdr_pkg::STORE_SLOTS-1:0][7:0] store_view;
	logic             out_valid_q;
	cdr_pkg::result_t res_q, res_d;
	logic             res_valid;
	logic             go;
	logic             pop_ok;
	logic [7:0]       gap_inc;
	logic [3:0]       store_idx;
	logic [7:0]       count_raw;
	logic [2:0]       count;
	logic             body_more;

	for (genvar e = 0; e < cdr_pkg::STORE_SLOTS; e++) begin : g_view
		if (e < STORE_DEPTH) begin : g_real
			assign store_view[e] = store_q[e];
		end else begin : g_pad
			assign store_view[e] = 8'd0;
		end
	end

	assign pop_ok = pop && out_valid_q;
	assign go = q_valid && (!res_valid || !out_valid_q || pop);
	assign q_pop = go;
	assign empty = !out_valid_q;
	assign result = res_q;

	assign gap_inc = gap_q + 8'd1;
	assign store_idx = bytes_seen_q - 4'd1;
	assign count_raw = expected_length_q - cdr_pkg::MIN_FRAME_LENGTH;
	assign count = (count_raw > 8'(cdr_pkg::MAX_PAYLOAD)) ? cdr_pkg::MAX_PAYLOAD : count_raw[2:0];
	assign body_more = ({5'd0, bytes_seen_q} + 9'd1) < {1'b0, expected_length_q};

	always_comb begin
		phase_d = phase_q;
		expected_length_d = expected_length_q;
		bytes_seen_d = bytes_seen_q;
		running_crc_d = running_crc_q;
		gap_d = gap_q;
		store_we = '0;
		res_valid = 1'b0;
		res_d = '0;
		if (q_item.kind == cdr_pkg::KIND_TICK) begin
			if (phase_q != cdr_pkg::PH_IDLE) begin
				if (gap_inc >= gap_limit_ticks) begin
					res_valid = 1'b1;
					res_d.status = cdr_pkg::ST_TIMEOUT;
					res_d.frame_length = expected_length_q;
					phase_d = cdr_pkg::PH_IDLE;
					gap_d = 8'd0;
				end else begin
					gap_d = gap_inc;
				end
			end
		end else begin
			gap_d = 8'd0;
			case (phase_q)
				cdr_pkg::PH_IDLE: begin
					if (q_item.kind == cdr_pkg::KIND_START) begin
						phase_d = cdr_pkg::PH_LENGTH;
						expected_length_d = 8'd0;
					end else begin
						res_valid = 1'b1;
						res_d.status = cdr_pkg::ST_STRAY;
						res_d.stray_value = q_item.data;
					end
				end
				cdr_pkg::PH_LENGTH: begin
					if (q_item.data < cdr_pkg::MIN_FRAME_LENGTH || q_item.data > MAX_LEN) begin
						res_valid = 1'b1;
						res_d.status = cdr_pkg::ST_LEN;
						res_d.frame_length = q_item.data;
						phase_d = cdr_pkg::PH_IDLE;
					end else begin
						expected_length_d = q_item.data;
						running_crc_d = cdr_pkg::crc8_step(8'd0, q_item.data, crc_polynomial);
						bytes_seen_d = 4'd1;
						phase_d = cdr_pkg::PH_BODY;
					end
				end
				cdr_pkg::PH_BODY: begin
					if (body_more) begin
						for (int e = 0; e < STORE_DEPTH; e++) begin
							store_we[e] = (store_idx == 4'(e));
						end
						running_crc_d = cdr_pkg::crc8_step(running_crc_q, q_item.data,
							crc_polynomial);
						bytes_seen_d = bytes_seen_q + 4'd1;
					end else begin
						res_valid = 1'b1;
						res_d.frame_length = expected_length_q;
						if (q_item.data == running_crc_q) begin
							res_d.status = cdr_pkg::ST_OK;
							res_d.dest_address = store_view[0];
							res_d.op_code = store_view[1];
							res_d.payload_count = count;
							for (int k = 0; k < cdr_pkg::NUM_PAYLOAD; k++) begin
								if (3'(k) < count) begin
									res_d.payload[k] = store_view[2 + k];
								end
							end
						end else begin
							res_d.status = cdr_pkg::ST_CRC;
						end
						phase_d = cdr_pkg::PH_IDLE;
						bytes_seen_d = 4'd0;
					end
				end
				default: begin
					phase_d = cdr_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cdr_pkg::PH_IDLE;
			expected_length_q <= 8'd0;
			bytes_seen_q <= 4'd0;
			running_crc_q <= 8'd0;
			gap_q <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				phase_q <= phase_d;
				expected_length_q <= expected_length_d;
				bytes_seen_q <= bytes_seen_d;
				running_crc_q <= running_crc_d;
				gap_q <= gap_d;
			end
			if (go && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (pop_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			res_q <= res_d;
		end
		for (int e = 0; e < STORE_DEPTH; e++) begin
			if (go && store_we[e]) begin
				store_q[e] <= q_item.data;
			end
		end
	end

`ifndef SYNTHESIS
	a_body_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cdr_pkg::PH_BODY |->
			expected_length_q >= cdr_pkg::MIN_FRAME_LENGTH && expected_length_q <= MAX_LEN)
		else $error("body phase with out-of-range frame length");
	a_body_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cdr_pkg::PH_BODY |->
			bytes_seen_q != 4'd0 && {4'd0, bytes_seen_q} < expected_length_q)
		else $error("byte index outside frame");
	a_idle_gap: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cdr_pkg::PH_IDLE |-> gap_q == 8'd0)
		else $error("gap timer running while idle");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(res_q))
		else $error("pending result lost or changed");
`endif

endmodule

[rtl/crc8_datagram_receiver.sv]
// Top level: configuration registers, front classifier, queue and frame parser.
//
// channel   direction  handshake        word
// input     in         push / full      cmd, rx_byte
// result    out        empty / pop      status .. stray_value
// config    in         APB psel/penable start_byte, crc_polynomial, gap_limit_ticks
//
// One word per cycle sustained while results are popped; the parser takes one queued word each cycle unless it holds.
// An input word passes the queue register, then the result register, before its result appears.
// The parser holds only when it has a result and the result register is still unpopped;
// the two-entry queue then fills and raises full.
// Reset is asynchronous; no clearing pass, the frame store needs none.
module crc8_datagram_receiver #(
	parameter int unsigned MAX_FRAME_LENGTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic [7:0]                        rx_byte,
	output logic                              empty,
	input  logic                              pop,
	output logic [2:0]                        status,
	output logic [7:0]                        frame_length,
	output logic [7:0]                        dest_address,
	output logic [7:0]                        op_code,
	output logic [2:0]                        payload_count,
	output logic [7:0]                        payload_0,
	output logic [7:0]                        payload_1,
	output logic [7:0]                        payload_2,
	output logic [7:0]                        payload_3,
	output logic [7:0]                        stray_value,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cdr_pkg::ADDR_WIDTH-1:0]    paddr,
	input  logic [cdr_pkg::DATA_WIDTH-1:0]    pwdata,
	output logic [cdr_pkg::DATA_WIDTH-1:0]    prdata,
	output logic                              pready
);

	logic [7:0]       start_byte_q;
	logic [7:0]       crc_polynomial_q;
	logic [7:0]       gap_limit_ticks_q;
	logic             q_push;
	logic             q_full;
	logic             q_valid;
	logic             q_pop;
	cdr_pkg::item_t   wr_item;
	cdr_pkg::item_t   rd_item;
	cdr_pkg::result_t res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= cdr_pkg::RESET_START_BYTE;
			crc_polynomial_q <= cdr_pkg::RESET_CRC_POLYNOMIAL;
			gap_limit_ticks_q <= cdr_pkg::RESET_GAP_LIMIT_TICKS;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				cdr_pkg::REG_START_BYTE: start_byte_q <= pwdata[7:0];
				cdr_pkg::REG_CRC_POLYNOMIAL: crc_polynomial_q <= pwdata[7:0];
				cdr_pkg::REG_GAP_LIMIT_TICKS: gap_limit_ticks_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cdr_pkg::REG_START_BYTE: prdata = {24'd0, start_byte_q};
			cdr_pkg::REG_CRC_POLYNOMIAL: prdata = {24'd0, crc_polynomial_q};
			cdr_pkg::REG_GAP_LIMIT_TICKS: prdata = {24'd0, gap_limit_ticks_q};
			default: prdata = '0;
		endcase
	end

	cdr_front u_front (
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.rx_byte    (rx_byte),
		.start_byte (start_byte_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (wr_item)
	);

	cdr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_item  (wr_item),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_item  (rd_item)
	);

	cdr_back #(
		.MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_item          (rd_item),
		.q_pop           (q_pop),
		.crc_polynomial  (crc_polynomial_q),
		.gap_limit_ticks (gap_limit_ticks_q),
		.pop             (pop),
		.empty           (empty),
		.result          (res)
	);

	assign status = res.status;
	assign frame_length = res.frame_length;
	assign dest_address = res.dest_address;
	assign op_code = res.op_code;
	assign payload_count = res.payload_count;
	assign payload_0 = res.payload[0];
	assign payload_1 = res.payload[1];
	assign payload_2 = res.payload[2];
	assign payload_3 = res.payload[3];
	assign stray_value = res.stray_value;

endmodule

[verif/crc8_datagram_receiver_test.sv]
// Self-checking testbench for the CRC-8 datagram receiver: byte/tick traffic against a predictor.
`timescale 1ns / 1ps

module crc8_datagram_receiver_test;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;
	localparam int unsigned MAX_LEN = 8;

	class datagram_tracker;
		logic [7:0] start_code;
		logic [7:0] poly;
		logic [7:0] gap_limit;
		cdr_pkg::phase_t phase;
		logic [7:0] length_seen;
		logic [3:0] index;
		logic [7:0] crc;
		logic [7:0] store [cdr_pkg::STORE_SLOTS];
		logic [7:0] gap_count;
		cdr_pkg::result_t owed [$];
		int errors;

		function new();
			start_code = cdr_pkg::RESET_START_BYTE;
			poly = cdr_pkg::RESET_CRC_POLYNOMIAL;
			gap_limit = cdr_pkg::RESET_GAP_LIMIT_TICKS;
			phase = cdr_pkg::PH_IDLE;
			length_seen = 8'h00;
			index = 4'h0;
			crc = 8'h00;
			gap_count = 8'h00;
			foreach (store[i]) store[i] = 8'h00;
			errors = 0;
		endfunction

		static function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b, logic [7:0] p);
			logic [7:0] r;
			r = c ^ b;
			repeat (8) r = (r >> 1) ^ (r[0] ? p : 8'h00);
			return r;
		endfunction

		task report(string msg);
			$display("%0t: mismatch: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(logic [1:0] idx, logic [7:0] v);
			case (idx)
				cdr_pkg::REG_START_BYTE: start_code = v;
				cdr_pkg::REG_CRC_POLYNOMIAL: poly = v;
				cdr_pkg::REG_GAP_LIMIT_TICKS: gap_limit = v;
				default: ;
			endcase
		endfunction

		function void note_word(logic c, logic [7:0] b);
			cdr_pkg::result_t r;
			logic [7:0] count;
			r = '0;
			if (c == CMD_TICK) begin
				if (phase == cdr_pkg::PH_IDLE)
					return;
				gap_count = gap_count + 8'd1;
				if (gap_count >= gap_limit) begin
					r.status = cdr_pkg::ST_TIMEOUT;
					r.frame_length = length_seen;
					phase = cdr_pkg::PH_IDLE;
					gap_count = 8'h00;
					owed.push_back(r);
				end
				return;
			end
			gap_count = 8'h00;
			case (phase)
				cdr_pkg::PH_IDLE: begin
					if (b == start_code) begin
						phase = cdr_pkg::PH_LENGTH;
						length_seen = 8'h00;
					end else begin
						r.status = cdr_pkg::ST_STRAY;
						r.stray_value = b;
						owed.push_back(r);
					end
				end
				cdr_pkg::PH_LENGTH: begin
					if (b < cdr_pkg::MIN_FRAME_LENGTH || b > MAX_LEN) begin
						r.status = cdr_pkg::ST_LEN;
						r.frame_length = b;
						phase = cdr_pkg::PH_IDLE;
						owed.push_back(r);
					end else begin
						length_seen = b;
						crc = crc8_next(8'h00, b, poly);
						index = 4'd1;
						phase = cdr_pkg::PH_BODY;
					end
				end
				default: begin
					if (int'(index) + 1 < int'(length_seen)) begin
						if (int'(index) - 1 < cdr_pkg::STORE_SLOTS)
							store[index - 4'd1] = b;
						crc = crc8_next(crc, b, poly);
						index = index + 4'd1;
					end else begin
						r.frame_length = length_seen;
						if (b == crc) begin
							count = length_seen - 8'd4;
							if (count > 8'd4)
								count = 8'd4;
							r.status = cdr_pkg::ST_OK;
							r.dest_address = store[0];
							r.op_code = store[1];
							r.payload_count = count[2:0];
							for (int k = 0; k < int'(count); k++)
								r.payload[k] = store[2 + k];
						end else begin
							r.status = cdr_pkg::ST_CRC;
						end
						phase = cdr_pkg::PH_IDLE;
						index = 4'h0;
						owed.push_back(r);
					end
				end
			endcase
		endfunction

		task same(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s: got %0d, expected %0d", name, got, want));
		endtask

		task check_report(cdr_pkg::result_t got);
			cdr_pkg::result_t want;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result, status %0d length %0d stray %0d",
					got.status, got.frame_length, got.stray_value));
				return;
			end
			want = owed.pop_front();
			same("status", got.status, want.status);
			same("frame_length", got.frame_length, want.frame_length);
			same("dest_address", got.dest_address, want.dest_address);
			same("op_code", got.op_code, want.op_code);
			same("payload_count", got.payload_count, want.payload_count);
			for (int k = 0; k < cdr_pkg::NUM_PAYLOAD; k++)
				same($sformatf("payload_%0d", k), got.payload[k], want.payload[k]);
			same("stray_value", got.stray_value, want.stray_value);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic cmd;
	logic [7:0] rx_byte;
	logic empty;
	logic pop;
	logic [2:0] status;
	logic [7:0] frame_length;
	logic [7:0] dest_address;
	logic [7:0] op_code;
	logic [2:0] payload_count;
	logic [7:0] payload_0;
	logic [7:0] payload_1;
	logic [7:0] payload_2;
	logic [7:0] payload_3;
	logic [7:0] stray_value;
	logic psel;
	logic penable;
	logic pwrite;
	logic [cdr_pkg::ADDR_WIDTH-1:0] paddr;
	logic [cdr_pkg::DATA_WIDTH-1:0] pwdata;
	logic [cdr_pkg::DATA_WIDTH-1:0] prdata;
	logic pready;

	datagram_tracker tracker;
	int unsigned send_quiet;
	int unsigned take_quiet;
	int unsigned sent;
	bit tick_noise;

	crc8_datagram_receiver dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("crc8_datagram_receiver_test: FAIL");
		$finish;
	end

	function automatic int unsigned draw_wait(inout int unsigned quiet);
		if (quiet != 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			quiet = $urandom_range(8, 48);
		return $urandom_range(0, 17);
	endfunction

	task automatic send_word(input logic c, input logic [7:0] b);
		int unsigned gap;
		gap = draw_wait(send_quiet);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		rx_byte <= b;
		do @(posedge clk); while (full);
		if (c == CMD_BYTE || tracker.phase != cdr_pkg::PH_IDLE)
			sent++;
		tracker.note_word(c, b);
	endtask

	task automatic settle();
		push <= 1'b0;
		for (int n = 0; n < 20000 && tracker.owed.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= cdr_pkg::ADDR_WIDTH'(4 * idx);
		pwdata <= cdr_pkg::DATA_WIDTH'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		tracker.set_reg(idx, v);
	endtask

	task automatic sprinkle_ticks();
		int unsigned lim;
		lim = (tracker.gap_limit - 1 < 4) ? tracker.gap_limit - 1 : 4;
		if (tick_noise && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(0, lim)) send_word(CMD_TICK, 8'($urandom()));
	endtask

	task automatic send_datagram(input logic [7:0] body [$], input bit good);
		logic [7:0] len;
		logic [7:0] c;
		len = 8'(body.size() + 2);
		c = datagram_tracker::crc8_next(8'h00, len, tracker.poly);
		foreach (body[i]) c = datagram_tracker::crc8_next(c, body[i], tracker.poly);
		if (!good)
			c = c ^ 8'($urandom_range(1, 255));
		send_word(CMD_BYTE, tracker.start_code);
		sprinkle_ticks();
		send_word(CMD_BYTE, len);
		foreach (body[i]) begin
			sprinkle_ticks();
			send_word(CMD_BYTE, body[i]);
		end
		sprinkle_ticks();
		send_word(CMD_BYTE, c);
	endtask

	task automatic abandon_frame();
		int unsigned keep;
		send_word(CMD_BYTE, tracker.start_code);
		keep = $urandom_range(0, 6);
		if (keep > 0)
			send_word(CMD_BYTE, 8'($urandom_range(4, MAX_LEN)));
		repeat (keep > 0 ? keep - 1 : 0) send_word(CMD_BYTE, 8'($urandom()));
		repeat (tracker.gap_limit) send_word(CMD_TICK, 8'($urandom()));
	endtask

	task automatic random_traffic(input int unsigned words);
		int unsigned stop;
		int unsigned pick;
		int unsigned plen;
		logic [7:0] body [$];
		stop = sent + words;
		while (sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				body = {};
				plen = $urandom_range(4, MAX_LEN);
				repeat (plen - 2) body.push_back(8'($urandom()));
				send_datagram(body, $urandom_range(0, 6) != 0);
			end else if (pick < 80) begin
				send_word(CMD_BYTE, tracker.start_code);
				send_word(CMD_BYTE, $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
					: 8'($urandom_range(9, 255)));
			end else if (pick < 88) begin
				if (tracker.gap_limit <= 32 || $urandom_range(0, 7) == 0)
					abandon_frame();
			end else if (pick < 97) begin
				repeat ($urandom_range(1, 4)) send_word(CMD_BYTE, 8'($urandom()));
			end else begin
				repeat ($urandom_range(1, 3)) send_word(CMD_TICK, 8'($urandom()));
			end
			if ($urandom_range(0, 149) == 0)
				settle();
		end
	endtask

	initial begin : take_results
		int unsigned stall;
		cdr_pkg::result_t got;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(take_quiet);
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got = {status, frame_length, dest_address, op_code, payload_count,
				payload_3, payload_2, payload_1, payload_0, stray_value};
			tracker.check_report(got);
		end
	end

	initial begin : stimulus
		logic [7:0] body [$];
		tracker = new();
		send_quiet = 0;
		take_quiet = 0;
		sent = 0;
		tick_noise = 1'b0;
		arst_n <= 1'b0;
		push <= 1'b0;
		cmd <= CMD_BYTE;
		rx_byte <= 8'h00;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(CMD_TICK, 8'hFF);
		send_word(CMD_BYTE, 8'h00);
		send_word(CMD_BYTE, 8'hFF);
		send_word(CMD_BYTE, tracker.start_code);
		send_word(CMD_BYTE, 8'd3);
		send_word(CMD_BYTE, tracker.start_code);
		send_word(CMD_BYTE, 8'd9);
		body = {tracker.start_code, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55};
		send_datagram(body, 1'b1);
		body = {8'hFF, 8'hFF};
		send_datagram(body, 1'b1);
		body = {8'h01, 8'h80, 8'h7E};
		send_datagram(body, 1'b0);

		tick_noise = 1'b1;
		random_traffic(300);

		settle();
		write_reg(cdr_pkg::REG_START_BYTE, 8'h00);
		write_reg(cdr_pkg::REG_CRC_POLYNOMIAL, 8'h00);
		write_reg(cdr_pkg::REG_GAP_LIMIT_TICKS, 8'd1);
		send_word(CMD_BYTE, 8'h00);
		send_word(CMD_TICK, 8'h5A);
		send_word(CMD_BYTE, 8'h00);
		send_word(CMD_BYTE, 8'd5);
		send_word(CMD_TICK, 8'hA5);
		random_traffic(300);

		settle();
		write_reg(cdr_pkg::REG_START_BYTE, 8'hFF);
		write_reg(cdr_pkg::REG_CRC_POLYNOMIAL, 8'hFF);
		write_reg(cdr_pkg::REG_GAP_LIMIT_TICKS, 8'd255);
		random_traffic(300);

		repeat (3) begin
			settle();
			write_reg(cdr_pkg::REG_START_BYTE, 8'($urandom()));
			write_reg(cdr_pkg::REG_CRC_POLYNOMIAL, 8'($urandom()));
			write_reg(cdr_pkg::REG_GAP_LIMIT_TICKS, 8'($urandom_range(1, 24)));
			random_traffic(330);
		end

		settle();
		if (tracker.owed.size() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.owed.size()));
		if (tracker.errors == 0)
			$display("crc8_datagram_receiver_test: PASS");
		else
			$display("crc8_datagram_receiver_test: FAIL");
		$finish;
	end

endmodule
